[rtl/prm_pkg.sv]
// ----------------------------------------------------------------------------
// Power rail manager package
// Shared types, codes and constants for the power rail manager.
// ----------------------------------------------------------------------------
`default_nettype none

package prm_pkg;

	localparam logic [2:0] OP_INIT     = 3'd0;
	localparam logic [2:0] OP_ENABLE   = 3'd1;
	localparam logic [2:0] OP_DISABLE  = 3'd2;
	localparam logic [2:0] OP_SHUTDOWN = 3'd3;
	localparam logic [2:0] OP_MEASURE  = 3'd4;
	localparam logic [2:0] OP_QUERY    = 3'd5;

	localparam logic [1:0] CFG_OPTIONAL = 2'd0;
	localparam logic [1:0] CFG_LOW      = 2'd1;
	localparam logic [1:0] CFG_CRITICAL = 2'd2;

	localparam logic [1:0] ALERT_NONE     = 2'd0;
	localparam logic [1:0] ALERT_LOW      = 2'd1;
	localparam logic [1:0] ALERT_CRITICAL = 2'd2;

	localparam int unsigned CELL_COUNT = 2;

	localparam int unsigned BAT_MV_SCALE = 6600;
	localparam int unsigned SOL_MV_SCALE = 9900;
	localparam int unsigned MA_SCALE     = 660;
	localparam int unsigned ADC_SHIFT    = 12;

	localparam int unsigned CHG_LO    = 3000 * CELL_COUNT;
	localparam int unsigned CHG_SPAN  = 1200 * CELL_COUNT;
	localparam int unsigned CHG_DIV   = 12 * CELL_COUNT;
	localparam int unsigned CHG_K     = 21;
	localparam int unsigned CHG_RECIP = ((1 << CHG_K) + CHG_DIV - 1) / CHG_DIV;
	localparam int unsigned CHG_D_W   = 14;

	localparam int unsigned SMW_K     = 33;
	localparam int unsigned SMW_RECIP = 8589935;

	localparam int unsigned Q_DEPTH = 2;

	localparam int unsigned CFG_W = 7;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_INIT,
		CMD_ENABLE,
		CMD_DISABLE,
		CMD_SHUTDOWN,
		CMD_MEASURE,
		CMD_QUERY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [3:0]  rail_idx;
		logic [12:0] bat_mv;
		logic [9:0]  bat_ma;
		logic [13:0] sol_mv;
		logic [9:0]  sol_ma;
	} cmd_t;

	typedef struct packed {
		logic [6:0]  rail_mask;
		logic        rail_on;
		logic [12:0] battery_millivolts;
		logic [9:0]  battery_milliamps;
		logic [13:0] solar_millivolts;
		logic [9:0]  solar_milliamps;
		logic [12:0] solar_milliwatts;
		logic [6:0]  charge_percent;
		logic [7:0]  load_deciwatts;
		logic [1:0]  alert_level;
		logic        shutdown_flag;
	} res_t;

	function automatic logic [4:0] rail_load_dw(input logic [3:0] idx);
		logic [4:0] v;
		case (idx)
			4'd0: v = 5'd5;
			4'd1: v = 5'd15;
			4'd2: v = 5'd8;
			4'd3: v = 5'd3;
			4'd4: v = 5'd20;
			4'd5: v = 5'd5;
			4'd6: v = 5'd10;
			default: v = 5'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

[rtl/prm_front.sv]
// ----------------------------------------------------------------------------
// Power rail manager front end
// Accepts items, classifies the opcode and scales the ADC codes.
// ----------------------------------------------------------------------------
`default_nettype none

module prm_front import prm_pkg::*; (
	input  wire logic        push,
	input  wire logic        q_full,
	input  wire logic [2:0]  opcode,
	input  wire logic [3:0]  rail_index,
	input  wire logic [11:0] battery_voltage_code,
	input  wire logic [11:0] battery_current_code,
	input  wire logic [11:0] solar_voltage_code,
	input  wire logic [11:0] solar_current_code,
	output logic             enq,
	output cmd_t             cmd
);

	logic [24:0] bat_mv_p;
	logic [21:0] bat_ma_p;
	logic [25:0] sol_mv_p;
	logic [21:0] sol_ma_p;

	assign enq = push && !q_full;

	always_comb begin
		bat_mv_p = 25'(battery_voltage_code) * 25'(BAT_MV_SCALE);
		bat_ma_p = 22'(battery_current_code) * 22'(MA_SCALE);
		sol_mv_p = 26'(solar_voltage_code) * 26'(SOL_MV_SCALE);
		sol_ma_p = 22'(solar_current_code) * 22'(MA_SCALE);

		cmd.rail_idx = rail_index;
		cmd.bat_mv   = bat_mv_p[ADC_SHIFT +: 13];
		cmd.bat_ma   = bat_ma_p[ADC_SHIFT +: 10];
		cmd.sol_mv   = sol_mv_p[ADC_SHIFT +: 14];
		cmd.sol_ma   = sol_ma_p[ADC_SHIFT +: 10];

		// Disabling the processor rail is never allowed, so it becomes a no-op here.
		case (opcode)
			OP_INIT:     cmd.kind = CMD_INIT;
			OP_ENABLE:   cmd.kind = CMD_ENABLE;
			OP_DISABLE:  cmd.kind = (rail_index == 4'd0) ? CMD_NOP : CMD_DISABLE;
			OP_SHUTDOWN: cmd.kind = CMD_SHUTDOWN;
			OP_MEASURE:  cmd.kind = CMD_MEASURE;
			OP_QUERY:    cmd.kind = CMD_QUERY;
			default:     cmd.kind = CMD_NOP;
		endcase
	end

endmodule

`default_nettype wire

[rtl/prm_queue.sv]
// ----------------------------------------------------------------------------
// Power rail manager command queue
// Short queue of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module prm_queue import prm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic enq,
	input  wire cmd_t enq_cmd,
	input  wire logic deq,
	output logic      full,
	output logic      valid,
	output cmd_t      head
);

	localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

	cmd_t             entry_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_enq;
	logic             do_deq;

	assign full   = (count_q == CNT_W'(Q_DEPTH));
	assign valid  = (count_q != '0);
	assign head   = entry_q[rd_ptr_q];
	assign do_enq = enq && !full;
	assign do_deq = deq && valid;

	always_ff @(posedge clk) begin
		if (do_enq) begin
			entry_q[wr_ptr_q] <= enq_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_enq) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_deq) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_enq && !do_deq) begin
				count_q <= count_q + 1'b1;
			end else if (do_deq && !do_enq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/prm_back.sv]
// ----------------------------------------------------------------------------
// Power rail manager back end
// Executes commands, holds rail and measurement state, derives the telemetry.
// ----------------------------------------------------------------------------
`default_nettype none

module prm_back import prm_pkg::*; #(
	parameter int unsigned RAIL_COUNT = 7
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	input  wire logic             q_valid,
	input  wire cmd_t             q_head,
	output logic                  q_deq,
	input  wire logic             pop,
	output logic                  res_valid,
	output res_t                  res
);

	typedef enum logic [1:0] {
		ST_EXEC,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [3:0]            opt_q;
	logic [6:0]            low_q;
	logic [6:0]            crit_q;
	logic [RAIL_COUNT-1:0] en_q;
	logic [12:0]           bat_mv_q;
	logic [9:0]            bat_ma_q;
	logic [13:0]           sol_mv_q;
	logic [9:0]            sol_ma_q;
	logic                  rail_on_q;
	logic                  shut_q;
	logic [23:0]           pwr_q;
	logic [CHG_D_W-1:0]    chg_d_q;
	logic                  chg_zero_q;
	logic                  chg_full_q;
	logic [7:0]            load_q;
	logic [12:0]           smw_q;
	logic                  res_valid_q;
	res_t                  res_q;

	logic [RAIL_COUNT-1:0] sel;
	logic [15:0]           init_w;
	logic [15:0]           keep_w;
	logic [15:0]           en_w;
	logic [15:0]           mv_w;
	logic [7:0]            load_sum;
	logic [47:0]           smw_prod;
	logic [31:0]           soc_prod;
	logic [6:0]            soc;
	logic [1:0]            alert;
	logic                  res_load;

	assign q_deq     = (state_q == ST_EXEC) && q_valid;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign res_load  = (state_q == ST_DONE) && (!res_valid_q || pop);

	always_comb begin
		sel    = {{(RAIL_COUNT - 1){1'b0}}, 1'b1} << q_head.rail_idx;
		init_w = {10'd0, opt_q, 2'b11};
		keep_w = 16'h0003;
		en_w   = 16'(en_q);
		mv_w   = 16'(bat_mv_q);

		load_sum = '0;
		for (int i = 0; i < RAIL_COUNT; i++) begin
			if (en_q[i]) begin
				load_sum = load_sum + 8'(rail_load_dw(4'(i)));
			end
		end

		smw_prod = 48'(pwr_q) * 48'(SMW_RECIP);
		soc_prod = 32'(chg_d_q) * 32'(CHG_RECIP);

		if (chg_full_q) begin
			soc = 7'd100;
		end else if (chg_zero_q) begin
			soc = 7'd0;
		end else begin
			soc = soc_prod[CHG_K +: 7];
		end

		if (soc < crit_q) begin
			alert = ALERT_CRITICAL;
		end else if (soc < low_q) begin
			alert = ALERT_LOW;
		end else begin
			alert = ALERT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_EXEC;
			opt_q       <= 4'd0;
			low_q       <= 7'd20;
			crit_q      <= 7'd10;
			en_q        <= '0;
			bat_mv_q    <= '0;
			bat_ma_q    <= '0;
			sol_mv_q    <= '0;
			sol_ma_q    <= '0;
			rail_on_q   <= 1'b0;
			shut_q      <= 1'b0;
			pwr_q       <= '0;
			chg_d_q     <= '0;
			chg_zero_q  <= 1'b1;
			chg_full_q  <= 1'b0;
			load_q      <= '0;
			smw_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_OPTIONAL: opt_q  <= cfg_wdata[3:0];
					CFG_LOW:      low_q  <= cfg_wdata[6:0];
					CFG_CRITICAL: crit_q <= cfg_wdata[6:0];
					default: ;
				endcase
			end

			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_EXEC: begin
					if (q_valid) begin
						rail_on_q <= (q_head.kind == CMD_QUERY) && |(en_q & sel);
						shut_q    <= (q_head.kind == CMD_SHUTDOWN);
						case (q_head.kind)
							CMD_INIT: begin
								en_q     <= init_w[RAIL_COUNT-1:0];
								bat_mv_q <= '0;
								bat_ma_q <= '0;
								sol_mv_q <= '0;
								sol_ma_q <= '0;
							end
							CMD_ENABLE:   en_q <= en_q | sel;
							CMD_DISABLE:  en_q <= en_q & ~sel;
							CMD_SHUTDOWN: en_q <= en_q & keep_w[RAIL_COUNT-1:0];
							CMD_MEASURE: begin
								bat_mv_q <= q_head.bat_mv;
								bat_ma_q <= q_head.bat_ma;
								sol_mv_q <= q_head.sol_mv;
								sol_ma_q <= q_head.sol_ma;
							end
							default: ;
						endcase
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					pwr_q      <= 24'(sol_mv_q) * 24'(sol_ma_q);
					chg_zero_q <= (mv_w <= 16'(CHG_LO));
					chg_full_q <= (mv_w >= 16'(CHG_LO + CHG_SPAN));
					chg_d_q    <= CHG_D_W'(mv_w - 16'(CHG_LO));
					load_q     <= load_sum;
					state_q    <= ST_DIV;
				end
				ST_DIV: begin
					smw_q   <= smw_prod[SMW_K +: 13];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_load) begin
						res_q.rail_mask          <= en_w[6:0];
						res_q.rail_on            <= rail_on_q;
						res_q.battery_millivolts <= bat_mv_q;
						res_q.battery_milliamps  <= bat_ma_q;
						res_q.solar_millivolts   <= sol_mv_q;
						res_q.solar_milliamps    <= sol_ma_q;
						res_q.solar_milliwatts   <= smw_q;
						res_q.charge_percent     <= soc;
						res_q.load_deciwatts     <= load_q;
						res_q.alert_level        <= alert;
						res_q.shutdown_flag      <= shut_q;
						state_q                  <= ST_EXEC;
					end
				end
				default: state_q <= ST_EXEC;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/power_rail_manager_with_soc_top.sv]
// A pushed item waits in the command queue until the back end takes it. The back end runs
// a four-step sequence (execute, power product, power scaling, charge and alert) that shares
// one set of registers, registers the result and takes no new item until it is done.
// A two-entry command queue lets the front end take items while the back end works.
// Asynchronous reset clears the rails, the measurements and the queue, and sets the
// registers to optional mask 0, low charge 20 and critical charge 10.
// ----------------------------------------------------------------------------
// Power rail manager top level
// Rail enable control with battery and solar housekeeping telemetry.
// ----------------------------------------------------------------------------
`default_nettype none

module power_rail_manager_with_soc_top import prm_pkg::*; #(
	parameter int unsigned RAIL_COUNT = 7
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [2:0]       opcode,
	input  wire logic [3:0]       rail_index,
	input  wire logic [11:0]      battery_voltage_code,
	input  wire logic [11:0]      battery_current_code,
	input  wire logic [11:0]      solar_voltage_code,
	input  wire logic [11:0]      solar_current_code,
	output logic                  empty,
	input  wire logic             pop,
	output logic [6:0]            rail_mask,
	output logic                  rail_on,
	output logic [12:0]           battery_millivolts,
	output logic [9:0]            battery_milliamps,
	output logic [13:0]           solar_millivolts,
	output logic [9:0]            solar_milliamps,
	output logic [12:0]           solar_milliwatts,
	output logic [6:0]            charge_percent,
	output logic [7:0]            load_deciwatts,
	output logic [1:0]            alert_level,
	output logic                  shutdown_flag
);

	logic enq;
	cmd_t enq_cmd;
	logic q_full;
	logic q_valid;
	cmd_t q_head;
	logic q_deq;
	logic res_valid;
	res_t res;

	prm_front u_front (
		.push                 (push),
		.q_full               (q_full),
		.opcode               (opcode),
		.rail_index           (rail_index),
		.battery_voltage_code (battery_voltage_code),
		.battery_current_code (battery_current_code),
		.solar_voltage_code   (solar_voltage_code),
		.solar_current_code   (solar_current_code),
		.enq                  (enq),
		.cmd                  (enq_cmd)
	);

	prm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.enq     (enq),
		.enq_cmd (enq_cmd),
		.deq     (q_deq),
		.full    (q_full),
		.valid   (q_valid),
		.head    (q_head)
	);

	prm_back #(
		.RAIL_COUNT (RAIL_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_deq     (q_deq),
		.pop       (pop),
		.res_valid (res_valid),
		.res       (res)
	);

	assign full               = q_full;
	assign empty              = !res_valid;
	assign rail_mask          = res.rail_mask;
	assign rail_on            = res.rail_on;
	assign battery_millivolts = res.battery_millivolts;
	assign battery_milliamps  = res.battery_milliamps;
	assign solar_millivolts   = res.solar_millivolts;
	assign solar_milliamps    = res.solar_milliamps;
	assign solar_milliwatts   = res.solar_milliwatts;
	assign charge_percent     = res.charge_percent;
	assign load_deciwatts     = res.load_deciwatts;
	assign alert_level        = res.alert_level;
	assign shutdown_flag      = res.shutdown_flag;

endmodule

`default_nettype wire

[rtl/prm_checker.sv]
// ----------------------------------------------------------------------------
// Power rail manager port checker
// Checks the result ports of the power rail manager over time.
// ----------------------------------------------------------------------------
`default_nettype none

module prm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [6:0] rail_mask,
	input wire logic       rail_on,
	input wire logic [6:0] charge_percent,
	input wire logic [1:0] alert_level,
	input wire logic       shutdown_flag
);

	a_shutdown_mask: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && shutdown_flag |-> rail_mask[6:2] == 5'd0)
		else $error("Shutdown result shows an optional rail still enabled.");

	a_shutdown_query: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && shutdown_flag |-> !rail_on)
		else $error("Shutdown result also reports a queried rail.");

	a_charge_alert: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> charge_percent <= 7'd100 && alert_level != 2'd3)
		else $error("Charge or alert out of range.");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("Result withdrawn before it was taken.");

endmodule

bind power_rail_manager_with_soc_top prm_checker u_prm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.rail_mask      (rail_mask),
	.rail_on        (rail_on),
	.charge_percent (charge_percent),
	.alert_level    (alert_level),
	.shutdown_flag  (shutdown_flag)
);

`default_nettype wire

[tb/power_rail_manager_with_soc_top_test.sv]
// ----------------------------------------------------------------------------
// Power rail manager testbench
// Sends rail commands and measure items through the push side, and checks
// every result popped against a cycle-free model of the rails, the stored
// telemetry, the charge estimate and the alert. The sender runs in bursts,
// the receiver stalls on a changing mask, and the configuration changes
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module power_rail_manager_with_soc_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import prm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_PHASES = 7;
	localparam int unsigned ITEMS_PER_PHASE = 100;
	localparam int unsigned RAILS = 7;
	localparam int unsigned CHARGE_FLOOR_MV = 3000 * CELL_COUNT;
	localparam int unsigned CHARGE_SPAN_MV = 1200 * CELL_COUNT;

	typedef struct {
		logic [2:0]  op;
		logic [3:0]  rail;
		logic [11:0] bat_v;
		logic [11:0] bat_i;
		logic [11:0] sol_v;
		logic [11:0] sol_i;
	} rail_cmd_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              push = 1'b0;
	logic              full;
	logic [2:0]        opcode = '0;
	logic [3:0]        rail_index = '0;
	logic [11:0]       battery_voltage_code = '0;
	logic [11:0]       battery_current_code = '0;
	logic [11:0]       solar_voltage_code = '0;
	logic [11:0]       solar_current_code = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [6:0]        rail_mask;
	logic              rail_on;
	logic [12:0]       battery_millivolts;
	logic [9:0]        battery_milliamps;
	logic [13:0]       solar_millivolts;
	logic [9:0]        solar_milliamps;
	logic [12:0]       solar_milliwatts;
	logic [6:0]        charge_percent;
	logic [7:0]        load_deciwatts;
	logic [1:0]        alert_level;
	logic              shutdown_flag;

	rail_cmd_t   pending_cmds[$];
	res_t        expected_telemetry[$];
	rail_cmd_t   driven_cmd;
	res_t        oldest_expected;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned stall_tick = 0;
	logic [7:0]  stall_mask = 8'hFF;
	int unsigned cycle_count = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;

	logic [6:0]  model_rails;
	logic [12:0] model_bat_mv;
	logic [9:0]  model_bat_ma;
	logic [13:0] model_sol_mv;
	logic [9:0]  model_sol_ma;
	logic [3:0]  model_optional;
	logic [6:0]  model_low;
	logic [6:0]  model_critical;

	power_rail_manager_with_soc_top dut (.*);

	always #1 clk = ~clk;

	function automatic res_t predict_telemetry(input rail_cmd_t c);
		res_t        r;
		int unsigned rail_load [RAILS] = '{5, 15, 8, 3, 20, 5, 10};
		int unsigned load_sum;
		int unsigned soc;
		int unsigned mv;
		bit          in_range;
		r = '0;
		load_sum = 0;
		in_range = c.rail < RAILS;
		case (c.op)
			OP_INIT: begin
				model_rails = {1'b0, model_optional, 2'b11};
				model_bat_mv = '0;
				model_bat_ma = '0;
				model_sol_mv = '0;
				model_sol_ma = '0;
			end
			OP_ENABLE: begin
				if (in_range)
					model_rails[c.rail] = 1'b1;
			end
			OP_DISABLE: begin
				if (in_range && c.rail != 4'd0)
					model_rails[c.rail] = 1'b0;
			end
			OP_SHUTDOWN: begin
				model_rails = model_rails & 7'b0000011;
				r.shutdown_flag = 1'b1;
			end
			OP_MEASURE: begin
				model_bat_mv = 13'((32'(c.bat_v) * 32'd6600) >> 12);
				model_bat_ma = 10'((32'(c.bat_i) * 32'd660) >> 12);
				model_sol_mv = 14'((32'(c.sol_v) * 32'd9900) >> 12);
				model_sol_ma = 10'((32'(c.sol_i) * 32'd660) >> 12);
			end
			OP_QUERY: begin
				if (in_range)
					r.rail_on = model_rails[c.rail];
			end
			default: begin
			end
		endcase
		for (int i = 0; i < RAILS; i++)
			if (model_rails[i])
				load_sum += rail_load[i];
		mv = model_bat_mv;
		if (mv <= CHARGE_FLOOR_MV)
			soc = 0;
		else if (mv >= CHARGE_FLOOR_MV + CHARGE_SPAN_MV)
			soc = 100;
		else
			soc = (mv - CHARGE_FLOOR_MV) * 100 / CHARGE_SPAN_MV;
		r.rail_mask = model_rails;
		r.battery_millivolts = model_bat_mv;
		r.battery_milliamps = model_bat_ma;
		r.solar_millivolts = model_sol_mv;
		r.solar_milliamps = model_sol_ma;
		r.solar_milliwatts = 13'((32'(model_sol_mv) * 32'(model_sol_ma)) / 32'd1000);
		r.charge_percent = 7'(soc);
		r.load_deciwatts = 8'(load_sum);
		if (soc < model_critical)
			r.alert_level = ALERT_CRITICAL;
		else if (soc < model_low)
			r.alert_level = ALERT_LOW;
		else
			r.alert_level = ALERT_NONE;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("result %0d: %s", results_seen, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	task automatic add_cmd(input logic [2:0] op, input logic [3:0] rail,
			input logic [11:0] bv, input logic [11:0] bi,
			input logic [11:0] sv, input logic [11:0] si);
		rail_cmd_t c;
		c.op = op;
		c.rail = rail;
		c.bat_v = bv;
		c.bat_i = bi;
		c.sol_v = sv;
		c.sol_i = si;
		pending_cmds.push_back(c);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			CFG_OPTIONAL: model_optional = value[3:0];
			CFG_LOW: model_low = value;
			CFG_CRITICAL: model_critical = value;
			default: begin
			end
		endcase
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || push || expected_telemetry.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				expected_telemetry.push_back(predict_telemetry(driven_cmd));
			if (!(push && full)) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					driven_cmd = pending_cmds.pop_front();
					opcode <= driven_cmd.op;
					rail_index <= driven_cmd.rail;
					battery_voltage_code <= driven_cmd.bat_v;
					battery_current_code <= driven_cmd.bat_i;
					solar_voltage_code <= driven_cmd.sol_v;
					solar_current_code <= driven_cmd.sol_i;
					push <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_telemetry.size() == 0) begin
					report_mismatch("item popped with nothing expected");
				end else begin
					oldest_expected = expected_telemetry.pop_front();
					check_field("rail_mask", rail_mask, oldest_expected.rail_mask);
					check_field("rail_on", rail_on, oldest_expected.rail_on);
					check_field("battery_millivolts", battery_millivolts,
						oldest_expected.battery_millivolts);
					check_field("battery_milliamps", battery_milliamps,
						oldest_expected.battery_milliamps);
					check_field("solar_millivolts", solar_millivolts,
						oldest_expected.solar_millivolts);
					check_field("solar_milliamps", solar_milliamps,
						oldest_expected.solar_milliamps);
					check_field("solar_milliwatts", solar_milliwatts,
						oldest_expected.solar_milliwatts);
					check_field("charge_percent", charge_percent,
						oldest_expected.charge_percent);
					check_field("load_deciwatts", load_deciwatts,
						oldest_expected.load_deciwatts);
					check_field("alert_level", alert_level, oldest_expected.alert_level);
					check_field("shutdown_flag", shutdown_flag, oldest_expected.shutdown_flag);
				end
				results_seen++;
			end
			stall_tick++;
			if (stall_tick % 48 == 0)
				stall_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom());
			pop <= stall_mask[stall_tick % 8];
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		rail_cmd_t   c;
		int unsigned pick;
		logic [3:0]  opt_setting;
		logic [6:0]  low_setting;
		logic [6:0]  crit_setting;
		model_rails = '0;
		model_bat_mv = '0;
		model_bat_ma = '0;
		model_sol_mv = '0;
		model_sol_ma = '0;
		model_optional = '0;
		model_low = 7'd20;
		model_critical = 7'd10;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values first, then every command, the index edges and the ADC extremes.
		add_cmd(OP_QUERY, 4'd0, 12'h000, 12'h000, 12'h000, 12'h000);
		add_cmd(OP_MEASURE, 4'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
		add_cmd(OP_INIT, 4'd15, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
		add_cmd(OP_MEASURE, 4'd0, 12'h000, 12'h000, 12'h000, 12'h000);
		add_cmd(OP_MEASURE, 4'd0, 12'd3724, 12'h800, 12'h800, 12'h800);
		add_cmd(OP_MEASURE, 4'd0, 12'd3740, 12'h555, 12'hAAA, 12'h555);
		add_cmd(OP_ENABLE, 4'd6, 12'h000, 12'h000, 12'h000, 12'h000);
		add_cmd(OP_ENABLE, 4'd7, 12'h000, 12'h000, 12'h000, 12'h000);
		add_cmd(OP_ENABLE, 4'd15, 12'h000, 12'h000, 12'h000, 12'h000);
		for (int r = 2; r < 6; r++)
			add_cmd(OP_ENABLE, 4'(r), 12'h000, 12'h000, 12'h000, 12'h000);
		add_cmd(OP_QUERY, 4'd6, 12'h000, 12'h000, 12'h000, 12'h000);
		add_cmd(OP_QUERY, 4'd7, 12'h000, 12'h000, 12'h000, 12'h000);
		add_cmd(OP_QUERY, 4'd15, 12'h000, 12'h000, 12'h000, 12'h000);
		add_cmd(OP_DISABLE, 4'd0, 12'h000, 12'h000, 12'h000, 12'h000);
		add_cmd(OP_DISABLE, 4'd15, 12'h000, 12'h000, 12'h000, 12'h000);
		add_cmd(OP_DISABLE, 4'd1, 12'h000, 12'h000, 12'h000, 12'h000);
		add_cmd(OP_QUERY, 4'd1, 12'h000, 12'h000, 12'h000, 12'h000);
		add_cmd(OP_SHUTDOWN, 4'd3, 12'h000, 12'h000, 12'h000, 12'h000);
		add_cmd(3'd6, 4'd2, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
		add_cmd(3'd7, 4'd9, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
		add_cmd(OP_MEASURE, 4'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
		add_cmd(OP_ENABLE, 4'd1, 12'h000, 12'h000, 12'h000, 12'h000);
		wait_idle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin opt_setting = 4'hF; low_setting = 7'd100; crit_setting = 7'd100; end
				1: begin opt_setting = 4'h0; low_setting = 7'd0; crit_setting = 7'd0; end
				2: begin opt_setting = 4'h5; low_setting = 7'd22; crit_setting = 7'd8; end
				3: begin opt_setting = 4'hA; low_setting = 7'd100; crit_setting = 7'd0; end
				4: begin opt_setting = 4'h3; low_setting = 7'd5; crit_setting = 7'd24; end
				default: begin
					opt_setting = 4'($urandom());
					low_setting = 7'($urandom_range(0, 30));
					crit_setting = 7'($urandom_range(0, 30));
				end
			endcase
			write_register(CFG_OPTIONAL, CFG_W'(opt_setting));
			write_register(CFG_LOW, low_setting);
			write_register(CFG_CRITICAL, crit_setting);
			@(posedge clk);
			cfg_we <= 1'b0;
			@(negedge clk);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 8)
					c.op = OP_INIT;
				else if (pick < 28)
					c.op = OP_ENABLE;
				else if (pick < 43)
					c.op = OP_DISABLE;
				else if (pick < 50)
					c.op = OP_SHUTDOWN;
				else if (pick < 78)
					c.op = OP_MEASURE;
				else if (pick < 94)
					c.op = OP_QUERY;
				else
					c.op = 3'($urandom_range(6, 7));
				c.rail = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(7, 15))
					: 4'($urandom_range(0, 6));
				c.bat_v = ($urandom_range(0, 2) == 0) ? 12'($urandom())
					: 12'($urandom_range(3700, 4095));
				c.bat_i = 12'($urandom());
				c.sol_v = 12'($urandom());
				c.sol_i = 12'($urandom());
				if ($urandom_range(0, 15) == 0) begin
					c.sol_v = 12'hFFF;
					c.sol_i = 12'hFFF;
				end
				pending_cmds.push_back(c);
			end
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
